[rtl/core/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the step/dir sequencer.
// ----------------------------------------------------------------------------
package sds_pkg;

    // default width of the remaining step counter
    localparam int COUNT_WIDTH_DEF = 31;

    // settle wait after reset
    localparam logic [7:0] SETTLE_RESET = 8'd10;

    // fixed widths of the item fields
    localparam int MOVE_WIDTH  = 32;
    localparam int STEPS_WIDTH = 31;
    localparam int OUT_TDATA_W = 40;

    // item kinds carried on tuser
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    // one input item
    typedef struct packed {
        logic                          kind;
        logic signed [MOVE_WIDTH-1:0]  move_steps;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic                    busy_res;
        logic [STEPS_WIDTH-1:0]  steps_left;
        logic                    dir_level;
        logic                    step_level;
        logic                    enable_level;
    } out_item_t;

    // handshake between input stage and sequencer stage
    typedef struct packed {
        logic valid;
        logic take;
    } stage_ctl_t;

endpackage

[rtl/core/sds_in_reg.sv]
// ----------------------------------------------------------------------------
// sds_in_reg
// Input register stage: captures one transaction per cycle from the slave
// side while it is empty or its held item is being taken, and holds it until the sequencer stage takes it.
// ----------------------------------------------------------------------------
module sds_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sds_pkg::in_item_t in_item,
    input  logic              take,
    output sds_pkg::in_item_t item,
    output logic              item_valid
);

    logic              valid_reg;
    logic              valid_next;
    sds_pkg::in_item_t item_reg;
    logic              load;

    // ready whenever the held item leaves this cycle or none is held
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    // valid bit update
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

[rtl/core/sds_seq.sv]
// ----------------------------------------------------------------------------
// sds_seq
// Sequencer stage: applies one tick or move to the phase machine and pins,
// and registers the resulting pin levels for the master side.
// ----------------------------------------------------------------------------
module sds_seq #(
    parameter int COUNT_WIDTH = sds_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  sds_pkg::in_item_t  item,
    input  logic               item_valid,
    output logic               take,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sds_pkg::out_item_t result
);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_SETTLE_ON  = 3'd1,
        PH_STEP       = 3'd2,
        PH_SETTLE_OFF = 3'd3,
        PH_DISABLE    = 3'd4
    } phase_t;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [7:0]               settle_reg;
    logic [7:0]               settle_cnt_reg;
    logic [7:0]               settle_cnt_next;
    logic                     high_half_reg;
    logic                     high_half_next;
    logic [COUNT_WIDTH-1:0]   remaining_reg;
    logic [COUNT_WIDTH-1:0]   remaining_next;
    logic                     enable_reg;
    logic                     enable_next;
    logic                     step_reg;
    logic                     step_next;
    logic                     dir_reg;
    logic                     dir_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    sds_pkg::out_item_t       result_reg;
    sds_pkg::out_item_t       result_next;
    logic                     fire;
    logic [7:0]               cnt_inc;
    logic                     settle_done;
    logic [31:0]              raw;
    logic [31:0]              mag;
    logic                     sat;

    // the stage moves when the output register is free or being drained
    assign take = item_valid && (!out_valid_reg || m_tready);
    assign fire = take;

    // settle counter step shared by both settle phases
    assign cnt_inc     = settle_cnt_reg + 8'd1;
    assign settle_done = cnt_inc > settle_reg;

    // move magnitude with saturation to the counter range
    assign raw = 32'(item.move_steps);
    assign mag = raw[31] ? (32'd0 - raw) : raw;
    assign sat = (mag >> COUNT_WIDTH) != 32'd0;

    // next state for one transaction
    always_comb
    begin
        phase_next      = phase_reg;
        settle_cnt_next = settle_cnt_reg;
        high_half_next  = high_half_reg;
        remaining_next  = remaining_reg;
        enable_next     = enable_reg;
        step_next       = step_reg;
        dir_next        = dir_reg;
        if (item.kind == sds_pkg::KIND_MOVE)
        begin
            if (raw != 32'd0)
            begin
                dir_next = raw[31];
            end
            remaining_next = sat ? COUNT_MAX : mag[COUNT_WIDTH-1:0];
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (remaining_reg != '0)
                    begin
                        enable_next = 1'b1;
                        phase_next  = PH_SETTLE_ON;
                    end
                end
                PH_SETTLE_ON,
                PH_SETTLE_OFF:
                begin
                    if (settle_done)
                    begin
                        settle_cnt_next = 8'd0;
                        phase_next = (phase_reg == PH_SETTLE_ON) ? PH_STEP : PH_DISABLE;
                    end
                    else
                    begin
                        settle_cnt_next = cnt_inc;
                    end
                end
                PH_STEP:
                begin
                    if (remaining_reg != '0)
                    begin
                        if (high_half_reg)
                        begin
                            high_half_next = 1'b0;
                            step_next      = 1'b1;
                        end
                        else
                        begin
                            step_next      = 1'b0;
                            high_half_next = 1'b1;
                            remaining_next = remaining_reg - COUNT_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        phase_next = PH_SETTLE_OFF;
                    end
                end
                PH_DISABLE:
                begin
                    enable_next = 1'b0;
                    phase_next  = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result fields from the updated state
    always_comb
    begin
        result_next.enable_level = enable_next;
        result_next.step_level   = step_next;
        result_next.dir_level    = dir_next;
        result_next.steps_left   = sds_pkg::STEPS_WIDTH'(remaining_next);
        result_next.busy_res     = (phase_next != PH_IDLE);
    end

    // output valid update
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            settle_reg     <= sds_pkg::SETTLE_RESET;
            settle_cnt_reg <= 8'd0;
            high_half_reg  <= 1'b0;
            remaining_reg  <= '0;
            enable_reg     <= 1'b0;
            step_reg       <= 1'b0;
            dir_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                settle_reg <= cfg_wdata;
            end
            if (fire)
            begin
                phase_reg      <= phase_next;
                settle_cnt_reg <= settle_cnt_next;
                high_half_reg  <= high_half_next;
                remaining_reg  <= remaining_next;
                enable_reg     <= enable_next;
                step_reg       <= step_next;
                dir_reg        <= dir_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

[rtl/core/stepper_step_dir_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_step_dir_sequencer
// Step/dir pulse sequencer for a stepper driver, driven by tick and move
// transactions, returning pin levels and remaining steps per transaction.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                        content
//  --------  ---  -----------------------------  -------------------------------
//  slave     in   s_tvalid s_tready s_tdata      move_steps (signed, 32 bits)
//                 s_tuser                        kind: 0 tick, 1 move
//  master    out  m_tvalid m_tready m_tdata      enable, step, dir, steps_left,
//                                                busy
//  config    in   cfg_we cfg_wdata               settle_ticks (8 bits)
//
//  One transaction per cycle sustained while m_tready is high; an accepted
//  transaction is loaded into the input register, and its result is loaded
//  into the result register when the sequencer stage takes it.
//  A stall on m_tready holds the result register and the input register; the
//  slave side keeps accepting while the input register is free or draining.
//  Reset puts the phase machine in idle, clears pins and count, and loads
//  settle_ticks with 10.
//
module stepper_step_dir_sequencer #(
    parameter int COUNT_WIDTH = sds_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] move_steps
    input  logic [0:0]                     s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sds_pkg::OUT_TDATA_W-1:0] m_tdata,  // [0] enable_level,
                                                      // [1] step_level,
                                                      // [2] dir_level,
                                                      // [33:3] steps_left,
                                                      // [34] busy_res,
                                                      // [39:35] zero
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata
);

    sds_pkg::in_item_t  in_item;
    sds_pkg::in_item_t  item;
    sds_pkg::out_item_t result;
    sds_pkg::stage_ctl_t ctl;

    // unpack slave side
    assign in_item.kind       = s_tuser[0];
    assign in_item.move_steps = s_tdata;

    // input register stage
    sds_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_item    (in_item),
        .take       (ctl.take),
        .item       (item),
        .item_valid (ctl.valid)
    );

    // sequencer and result register
    sds_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item       (item),
        .item_valid (ctl.valid),
        .take       (ctl.take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    // pack master side
    assign m_tdata = {5'd0, result.busy_res, result.steps_left, result.dir_level,
                      result.step_level, result.enable_level};

endmodule
